// ===== rtl/core/lms_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lms_pkg
// Shared types and codes for the linear move subdivider.
// ----------------------------------------------------------------------------
package lms_pkg;

    typedef enum logic [1:0] {
        OP_MUL  = 2'd0,
        OP_DIV  = 2'd1,
        OP_SQRT = 2'd2
    } lms_op_t;

    localparam logic [1:0] REQ_FEED  = 2'd0;
    localparam logic [1:0] REQ_POINT = 2'd1;

    localparam int LIMIT_BITS = 16;
    localparam int TAG_BITS   = 16;
    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd2000;

    // m_tuser bit positions
    localparam int U_ORIG = 0;
    localparam int U_HP   = 1;
    localparam int U_MANY = 2;
    localparam int U_BITS = 3;

endpackage
`default_nettype wire

// ===== rtl/core/lms_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lms_unit
// Shared iterative unit: shift-add multiply, restoring divide, square root.
// ----------------------------------------------------------------------------
module lms_unit
    import lms_pkg::*;
#(
    parameter int W  = 52,
    parameter int BW = 26
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire lms_op_t       op,
    input  wire logic [W-1:0]  opa,
    input  wire logic [BW-1:0] opb,
    output logic               done,
    output logic [W-1:0]       result
);

    localparam int RW = BW + 3;
    localparam int CW = $clog2(W + 1);

    lms_op_t         op_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [CW-1:0]   cnt_reg;
    logic [W-1:0]    acc_reg;
    logic [W-1:0]    a_reg;
    logic [BW-1:0]   b_reg;
    logic [RW-1:0]   rem_reg;

    logic [CW-1:0]   last_cnt;
    logic [RW-1:0]   rem2;
    logic [RW-1:0]   trial;
    logic            take;

    always_comb
    begin
        unique case (op_reg)
            OP_MUL:  last_cnt = CW'(BW - 1);
            OP_DIV:  last_cnt = CW'(W - 1);
            default: last_cnt = CW'(W / 2 - 1);
        endcase
        if (op_reg == OP_SQRT)
        begin
            rem2  = {rem_reg[RW-3:0], a_reg[W-1:W-2]};
            trial = {{(RW-BW-2){1'b0}}, acc_reg[BW-1:0], 2'b01};
        end
        else
        begin
            rem2  = {rem_reg[RW-2:0], a_reg[W-1]};
            trial = {{(RW-BW){1'b0}}, b_reg};
        end
        take = (rem2 >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_MUL;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                op_reg   <= op;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == last_cnt)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= '0;
            rem_reg <= '0;
            a_reg   <= opa;
            b_reg   <= opb;
        end
        else if (busy_reg)
        begin
            unique case (op_reg)
                OP_MUL:
                begin
                    acc_reg <= {acc_reg[W-2:0], 1'b0} + (b_reg[BW-1] ? a_reg : '0);
                    b_reg   <= {b_reg[BW-2:0], 1'b0};
                end
                OP_DIV:
                begin
                    a_reg   <= {a_reg[W-2:0], 1'b0};
                    rem_reg <= take ? rem2 - trial : rem2;
                    acc_reg <= {acc_reg[W-2:0], take};
                end
                default:
                begin
                    a_reg   <= {a_reg[W-3:0], 2'b00};
                    rem_reg <= take ? rem2 - trial : rem2;
                    acc_reg <= {acc_reg[W-2:0], take};
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign result = acc_reg;

endmodule
`default_nettype wire

// ===== rtl/core/lms_out.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lms_out
// Output register; takes a new word while the held one is being taken.
// ----------------------------------------------------------------------------
module lms_out
    import lms_pkg::*;
#(
    parameter int DW = 88
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    output logic                   push_ready,
    input  wire logic [DW-1:0]     push_data,
    input  wire logic [U_BITS-1:0] push_user,
    input  wire logic              push_last,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [DW-1:0]          m_tdata,
    output logic [U_BITS-1:0]      m_tuser,
    output logic                   m_tlast
);

    logic              full_reg;
    logic [DW-1:0]     data_reg;
    logic [U_BITS-1:0] user_reg;
    logic              last_reg;

    assign push_ready = !full_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            full_reg <= 1'b0;
        else if (push_ready)
            full_reg <= push_valid;
    end

    always_ff @(posedge clk)
    begin
        if (push_ready && push_valid)
        begin
            data_reg <= push_data;
            user_reg <= push_user;
            last_reg <= push_last;
        end
    end

    assign m_tvalid = full_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule
`default_nettype wire

// ===== rtl/core/linear_move_subdivider_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_move_subdivider_unit
// Splits long linear feed moves into legs no longer than leg_limit.
// ----------------------------------------------------------------------------
// channel  dir  tdata                                  tuser / tlast
// s_*      in   target_x, target_y, target_z, cmd_tag  tuser: req_type
// m_*      out  out_x, out_y, out_z, out_tag           tuser: is_original,
//                                                      has_point, too_many;
//                                                      tlast: last
// cfg_*    in   leg_limit, written when cfg_wen is high
//
// A word that is not split is accepted, then emitted. A feed move from a known
// position adds three squares, one square root and three scalings on the
// shared unit, then per intermediate point a check, three divides and an emit,
// and a last check. Reset clears the position and sets leg_limit to 2000. A
// stalled output holds the sequencer at its emit step.
// ----------------------------------------------------------------------------
module linear_move_subdivider_unit
    import lms_pkg::*;
#(
    parameter int MAX_PIECES = 64,
    parameter int COORD_BITS = 24,
    localparam int DW = ((3 * COORD_BITS + TAG_BITS + 7) / 8) * 8
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    s_tvalid,
    output logic                         s_tready,
    // target_x, target_y, target_z, cmd_tag, zero fill
    input  wire logic [DW-1:0]           s_tdata,
    // req_type
    input  wire logic [1:0]              s_tuser,
    output logic                         m_tvalid,
    input  wire logic                    m_tready,
    // out_x, out_y, out_z, out_tag, zero fill
    output logic [DW-1:0]                m_tdata,
    // is_original, has_point, too_many
    output logic [U_BITS-1:0]            m_tuser,
    output logic                         m_tlast,
    input  wire logic                    cfg_wen,
    input  wire logic [LIMIT_BITS-1:0]   cfg_wdata
);

    localparam int CB  = COORD_BITS;
    localparam int PW  = 3 * COORD_BITS + TAG_BITS;
    localparam int BW  = COORD_BITS + 2;
    localparam int W   = 2 * COORD_BITS + 4;
    localparam int NW  = $clog2(MAX_PIECES);

    typedef enum logic [3:0] {
        S_IDLE, S_SQ_GO, S_SQ_WAIT, S_SQRT_GO, S_SQRT_WAIT, S_NUM_GO, S_NUM_WAIT,
        S_CHECK, S_DIV_GO, S_DIV_WAIT, S_EMIT_MID, S_EMIT_ORIG
    } state_t;

    state_t                 state_reg;
    logic [LIMIT_BITS-1:0]  limit_reg;
    logic                   known_reg;
    logic [CB-1:0]          pos_reg [3];
    logic [CB-1:0]          tgt_reg [3];
    logic [CB:0]            d_reg   [3];
    logic [CB:0]            mag_reg [3];
    logic [W-1:0]           num_reg [3];
    logic [W-1:0]           nstep_reg [3];
    logic [CB-1:0]          pt_reg  [3];
    logic [TAG_BITS-1:0]    tag_reg;
    logic                   hp_reg;
    logic                   many_reg;
    logic [1:0]             axis_reg;
    logic [W-1:0]           sum_reg;
    logic [BW-1:0]          len_reg;
    logic [BW:0]            k_reg;
    logic [NW-1:0]          cnt_reg;
    logic                   start_reg;
    lms_op_t                op_reg;
    logic [W-1:0]           opa_reg;
    logic [BW-1:0]          opb_reg;

    logic                   u_done;
    logic [W-1:0]           u_res;
    logic                   push_valid;
    logic                   push_ready;
    logic [DW-1:0]          push_data;
    logic [U_BITS-1:0]      push_user;
    logic [CB-1:0]          t_in [3];
    logic [CB:0]            q_ext;
    logic [CB:0]            pos_ext;
    logic [CB:0]            mag_cur;

    assign s_tready = (state_reg == S_IDLE);
    assign t_in[0]  = s_tdata[CB-1:0];
    assign t_in[1]  = s_tdata[2*CB-1:CB];
    assign t_in[2]  = s_tdata[3*CB-1:2*CB];
    assign q_ext    = {1'b0, u_res[CB-1:0]};
    assign pos_ext  = {pos_reg[axis_reg][CB-1], pos_reg[axis_reg]};
    assign mag_cur  = d_reg[axis_reg][CB] ? (~d_reg[axis_reg] + 1'b1) : d_reg[axis_reg];

    always_comb
    begin
        push_valid = (state_reg == S_EMIT_MID) || (state_reg == S_EMIT_ORIG);
        push_data  = '0;
        push_user  = '0;
        if (state_reg == S_EMIT_ORIG)
        begin
            push_user[U_ORIG] = 1'b1;
            push_user[U_HP]   = hp_reg;
            push_user[U_MANY] = many_reg;
            if (hp_reg)
                push_data[PW-1:0] = {tag_reg, tgt_reg[2], tgt_reg[1], tgt_reg[0]};
            else
                push_data[PW-1:0] = {tag_reg, {(3*CB){1'b0}}};
        end
        else
        begin
            push_user[U_HP]   = 1'b1;
            push_data[PW-1:0] = {tag_reg, pt_reg[2], pt_reg[1], pt_reg[0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            limit_reg <= LIMIT_RESET;
            known_reg <= 1'b0;
            start_reg <= 1'b0;
            for (int i = 0; i < 3; i++)
                pos_reg[i] <= '0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (cfg_wen)
                limit_reg <= cfg_wdata;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        for (int i = 0; i < 3; i++)
                        begin
                            tgt_reg[i] <= t_in[i];
                            d_reg[i]   <= {t_in[i][CB-1], t_in[i]}
                                          - {pos_reg[i][CB-1], pos_reg[i]};
                        end
                        tag_reg  <= s_tdata[PW-1:3*CB];
                        hp_reg   <= (s_tuser == REQ_FEED) || (s_tuser == REQ_POINT);
                        many_reg <= 1'b0;
                        axis_reg <= '0;
                        sum_reg  <= '0;
                        cnt_reg  <= '0;
                        k_reg    <= {{(BW+1-LIMIT_BITS){1'b0}}, limit_reg};
                        if (s_tuser == REQ_FEED && known_reg)
                            state_reg <= S_SQ_GO;
                        else
                            state_reg <= S_EMIT_ORIG;
                    end
                end
                S_SQ_GO:
                begin
                    for (int i = 0; i < 3; i++)
                        mag_reg[i] <= d_reg[i][CB] ? -d_reg[i] : d_reg[i];
                    start_reg <= 1'b1;
                    op_reg    <= OP_MUL;
                    opa_reg   <= W'(mag_cur);
                    opb_reg   <= BW'(mag_cur);
                    state_reg <= S_SQ_WAIT;
                end
                S_SQ_WAIT:
                begin
                    if (u_done)
                    begin
                        sum_reg <= sum_reg + u_res;
                        if (axis_reg == 2'd2)
                            state_reg <= S_SQRT_GO;
                        else
                        begin
                            axis_reg  <= axis_reg + 1'b1;
                            state_reg <= S_SQ_GO;
                        end
                    end
                end
                S_SQRT_GO:
                begin
                    start_reg <= 1'b1;
                    op_reg    <= OP_SQRT;
                    opa_reg   <= sum_reg;
                    axis_reg  <= '0;
                    state_reg <= S_SQRT_WAIT;
                end
                S_SQRT_WAIT:
                begin
                    if (u_done)
                    begin
                        len_reg   <= u_res[BW-1:0];
                        state_reg <= S_NUM_GO;
                    end
                end
                S_NUM_GO:
                begin
                    start_reg <= 1'b1;
                    op_reg    <= OP_MUL;
                    opa_reg   <= W'(mag_reg[axis_reg]);
                    opb_reg   <= BW'(limit_reg);
                    state_reg <= S_NUM_WAIT;
                end
                S_NUM_WAIT:
                begin
                    if (u_done)
                    begin
                        num_reg[axis_reg]   <= u_res;
                        nstep_reg[axis_reg] <= u_res;
                        if (axis_reg == 2'd2)
                            state_reg <= S_CHECK;
                        else
                        begin
                            axis_reg  <= axis_reg + 1'b1;
                            state_reg <= S_NUM_GO;
                        end
                    end
                end
                S_CHECK:
                begin
                    axis_reg <= '0;
                    if (!({1'b0, len_reg} > k_reg))
                        state_reg <= S_EMIT_ORIG;
                    else if (cnt_reg == NW'(MAX_PIECES - 1))
                    begin
                        many_reg  <= 1'b1;
                        state_reg <= S_EMIT_ORIG;
                    end
                    else
                        state_reg <= S_DIV_GO;
                end
                S_DIV_GO:
                begin
                    start_reg <= 1'b1;
                    op_reg    <= OP_DIV;
                    opa_reg   <= num_reg[axis_reg];
                    opb_reg   <= len_reg;
                    state_reg <= S_DIV_WAIT;
                end
                S_DIV_WAIT:
                begin
                    if (u_done)
                    begin
                        pt_reg[axis_reg] <= CB'(d_reg[axis_reg][CB] ? pos_ext - q_ext
                                                                    : pos_ext + q_ext);
                        num_reg[axis_reg] <= num_reg[axis_reg] + nstep_reg[axis_reg];
                        if (axis_reg == 2'd2)
                            state_reg <= S_EMIT_MID;
                        else
                        begin
                            axis_reg  <= axis_reg + 1'b1;
                            state_reg <= S_DIV_GO;
                        end
                    end
                end
                S_EMIT_MID:
                begin
                    if (push_ready)
                    begin
                        k_reg     <= k_reg + (BW+1)'(limit_reg);
                        cnt_reg   <= cnt_reg + 1'b1;
                        state_reg <= S_CHECK;
                    end
                end
                S_EMIT_ORIG:
                begin
                    if (push_ready)
                    begin
                        if (hp_reg)
                        begin
                            for (int i = 0; i < 3; i++)
                                pos_reg[i] <= tgt_reg[i];
                            known_reg <= 1'b1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    lms_unit #(
        .W  (W),
        .BW (BW)
    ) u_unit (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start_reg),
        .op     (op_reg),
        .opa    (opa_reg),
        .opb    (opb_reg),
        .done   (u_done),
        .result (u_res)
    );

    lms_out #(
        .DW (DW)
    ) u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .push_user  (push_user),
        .push_last  (state_reg == S_EMIT_ORIG),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
`default_nettype wire

// ===== rtl/core/lms_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lms_checker
// Port-level checks for the linear move subdivider.
// ----------------------------------------------------------------------------
module lms_checker
    import lms_pkg::*;
#(
    parameter int DW = 88
)
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              s_tvalid,
    input wire logic              s_tready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [DW-1:0]     m_tdata,
    input wire logic [U_BITS-1:0] m_tuser,
    input wire logic              m_tlast
);

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    a_last_is_original: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == m_tuser[U_ORIG]))
        else $error("last word not the original");

    a_mid_has_point: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[U_ORIG] |-> m_tuser[U_HP] && !m_tuser[U_MANY])
        else $error("bad intermediate flags");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output word dropped");

endmodule

bind linear_move_subdivider_unit lms_checker #(.DW(DW)) u_lms_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire
